>>> sv/tpm_pkg.sv
`default_nettype none
package tpm_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int COUNT_BITS = NODE_BITS + 1;
  localparam int VALUE_BITS = 16;
  localparam int KEY_BITS   = 32;
  localparam int LEN_BITS   = 6;

  // Operation and status codes of the input and result words.
  localparam logic ACT_LOOKUP  = 1'b0;
  localparam logic ACT_INSERT  = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One write command to the node store; all enabled arrays share the address.
  typedef struct packed {
    logic                  left_en;
    logic                  right_en;
    logic                  value_en;
    logic [NODE_BITS-1:0]  addr;
    logic [NODE_BITS-1:0]  left_data;
    logic [NODE_BITS-1:0]  right_data;
    logic [VALUE_BITS-1:0] value_data;
  } wr_t;

  // Contents of one node as read back from the store.
  typedef struct packed {
    logic [NODE_BITS-1:0]  left;
    logic [NODE_BITS-1:0]  right;
    logic [VALUE_BITS-1:0] value;
  } node_t;

  // Controls shared by every cell of the key chain.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> sv/tpm_key_cell.sv
`default_nettype none
module tpm_key_cell (
  input  wire                 clk,
  input  tpm_pkg::cell_ctrl_t ctrl,
  input  wire                 load_bit,
  input  wire                 shift_in,
  output logic                bit_out
);

  // One key bit; on a shift it takes the bit of its lower neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bit_out <= load_bit;
    end else if (ctrl.shift) begin
      bit_out <= shift_in;
    end
  end

endmodule
`default_nettype wire

>>> sv/tpm_node_store.sv
`default_nettype none
module tpm_node_store (
  input  wire                                clk,
  input  wire [tpm_pkg::NODE_BITS-1:0]       rd_addr,
  output tpm_pkg::node_t                     rd_data,
  input  tpm_pkg::wr_t                       wr
);

  logic [tpm_pkg::NODE_BITS-1:0]  left_mem  [tpm_pkg::NODE_COUNT];
  logic [tpm_pkg::NODE_BITS-1:0]  right_mem [tpm_pkg::NODE_COUNT];
  logic [tpm_pkg::VALUE_BITS-1:0] value_mem [tpm_pkg::NODE_COUNT];

  always_ff @(posedge clk) begin
    if (wr.left_en) begin
      left_mem[wr.addr] <= wr.left_data;
    end
    if (wr.right_en) begin
      right_mem[wr.addr] <= wr.right_data;
    end
    if (wr.value_en) begin
      value_mem[wr.addr] <= wr.value_data;
    end
    rd_data.left  <= left_mem[rd_addr];
    rd_data.right <= right_mem[rd_addr];
    rd_data.value <= value_mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> sv/binary_trie_prefix_match_core.sv
`default_nettype none
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   action, key, prefix_len, value
// out      output     out_valid / out_stall match_value, used_default, status
// cfg      input      cfg_we                cfg_wdata (default value)
//
// A lookup visits the trie levels in turn and then posts the result word; the
// walk is paced by the node store's registered read port, one node read per
// cycle. An insert walks the existing path the same way and then decides: it
// either posts the result word at once (store full, or an absent path cleared)
// or clears and links each new node, writes the value and posts the result word.
// Reset is synchronous; it only clears control registers, the default value,
// the root node and the allocation count, so no clearing pass runs.
// A result word waits in the output register while the next input is taken.
module binary_trie_prefix_match_core (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               action,
  input  wire [31:0]                        key,
  input  wire [5:0]                         prefix_len,
  input  wire [15:0]                        value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [15:0]                       match_value,
  output logic                              used_default,
  output logic                              status,
  input  wire                               cfg_we,
  input  wire [15:0]                        cfg_wdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WALK   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_ZERO   = 3'd3;
  localparam logic [2:0] ST_LINK   = 3'd4;
  localparam logic [2:0] ST_WRVAL  = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  localparam int NB = tpm_pkg::NODE_BITS;
  localparam int VB = tpm_pkg::VALUE_BITS;
  localparam int KB = tpm_pkg::KEY_BITS;
  localparam int LB = tpm_pkg::LEN_BITS;
  localparam int CB = tpm_pkg::COUNT_BITS;

  logic [2:0]    state;
  logic [15:0]   default_value;

  // The root lives in flip-flops so that reset empties the trie at once.
  // Every other node is written when it is allocated, before any read of it.
  logic [NB-1:0] root_left;
  logic [NB-1:0] root_right;
  logic [VB-1:0] root_value;
  logic [CB-1:0] next_free;

  logic          op_insert;
  logic [LB-1:0] op_len;
  logic [VB-1:0] op_value;
  logic [NB-1:0] node;
  logic [LB-1:0] depth;
  logic [VB-1:0] best;
  logic          hit;

  logic [15:0]   res_match;
  logic          res_default;
  logic          res_status;

  tpm_pkg::node_t     rd_data;
  tpm_pkg::wr_t       wr;
  logic [NB-1:0]      rd_addr;
  tpm_pkg::cell_ctrl_t cell_ctrl;
  logic [KB-1:0]      chain;

  // The key chain: cell i holds key bit i and the top cell is the bit that
  // steers the current level. Each step down the trie shifts the chain by one.
  for (genvar i = 0; i < KB; i++) begin : g_cell
    if (i == 0) begin : g_first
      tpm_key_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .load_bit (key[i]),
        .shift_in (1'b0),
        .bit_out  (chain[i])
      );
    end else begin : g_rest
      tpm_key_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .load_bit (key[i]),
        .shift_in (chain[i-1]),
        .bit_out  (chain[i])
      );
    end
  end

  tpm_node_store u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  logic          accept;
  logic          out_free;
  logic          go_right;
  logic [NB-1:0] cur_left;
  logic [NB-1:0] cur_right;
  logic [VB-1:0] cur_value;
  logic [NB-1:0] child;
  logic          hit_now;
  logic [VB-1:0] best_now;
  logic [LB-1:0] need;
  logic [CB:0]   alloc_end;
  logic [NB-1:0] fresh;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign go_right = chain[KB-1];
  assign fresh    = next_free[NB-1:0];

  // Node data of the current level: the root registers at the root, else the
  // word read from the store in the previous cycle.
  always_comb begin
    if (node == '0) begin
      cur_left  = root_left;
      cur_right = root_right;
      cur_value = root_value;
    end else begin
      cur_left  = rd_data.left;
      cur_right = rd_data.right;
      cur_value = rd_data.value;
    end
    child    = go_right ? cur_right : cur_left;
    hit_now  = hit || (cur_value != '0);
    best_now = (cur_value != '0) ? cur_value : best;
    need      = op_len - depth;
    alloc_end = {1'b0, next_free} + {{(CB+1-LB){1'b0}}, need};
  end

  always_comb begin
    rd_addr         = child;
    cell_ctrl.load  = accept;
    cell_ctrl.shift = 1'b0;
    wr              = '0;
    unique case (state)
      ST_WALK: begin
        if (op_insert) begin
          cell_ctrl.shift = (depth != op_len) && (child != '0);
        end else begin
          cell_ctrl.shift = (depth != LB'(KB)) && (child != '0);
        end
      end
      ST_ZERO: begin
        wr.left_en  = 1'b1;
        wr.right_en = 1'b1;
        wr.value_en = 1'b1;
        wr.addr     = fresh;
      end
      ST_LINK: begin
        cell_ctrl.shift = 1'b1;
        wr.addr         = node;
        wr.left_data    = fresh;
        wr.right_data   = fresh;
        wr.left_en      = (node != '0) && !go_right;
        wr.right_en     = (node != '0) && go_right;
      end
      ST_WRVAL: begin
        wr.addr       = node;
        wr.value_data = op_value;
        wr.value_en   = (node != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      default_value <= '0;
      root_left     <= '0;
      root_right    <= '0;
      root_value    <= '0;
      next_free     <= CB'(1);
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        default_value <= cfg_wdata;
      end
      if (out_valid && !out_stall && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_insert <= (action == tpm_pkg::ACT_INSERT);
            op_len    <= (prefix_len > LB'(KB)) ? LB'(KB) : prefix_len;
            op_value  <= value[VB-1:0];
            node      <= '0;
            depth     <= '0;
            best      <= '0;
            hit       <= 1'b0;
            state     <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (op_insert) begin
            if ((depth == op_len) || (child == '0)) begin
              state <= ST_DECIDE;
            end else begin
              node  <= child;
              depth <= depth + LB'(1);
            end
          end else begin
            best <= best_now;
            hit  <= hit_now;
            if ((depth == LB'(KB)) || (child == '0)) begin
              res_match   <= hit_now ? 16'(best_now) : default_value;
              res_default <= !hit_now;
              res_status  <= tpm_pkg::STATUS_OK;
              state       <= ST_FIN;
            end else begin
              node  <= child;
              depth <= depth + LB'(1);
            end
          end
        end
        ST_DECIDE: begin
          res_match   <= '0;
          res_default <= 1'b0;
          priority if ((need != '0) && (op_value == '0)) begin
            // Clearing a prefix whose path is not there changes nothing.
            res_status <= tpm_pkg::STATUS_OK;
            state      <= ST_FIN;
          end else if (alloc_end > (CB+1)'(tpm_pkg::NODE_COUNT)) begin
            res_status <= tpm_pkg::STATUS_FULL;
            state      <= ST_FIN;
          end else if (need == '0) begin
            state <= ST_WRVAL;
          end else begin
            state <= ST_ZERO;
          end
        end
        ST_ZERO: begin
          state <= ST_LINK;
        end
        ST_LINK: begin
          if (node == '0) begin
            if (go_right) begin
              root_right <= fresh;
            end else begin
              root_left <= fresh;
            end
          end
          node      <= fresh;
          next_free <= next_free + CB'(1);
          depth     <= depth + LB'(1);
          state     <= ((depth + LB'(1)) == op_len) ? ST_WRVAL : ST_ZERO;
        end
        ST_WRVAL: begin
          if (node == '0) begin
            root_value <= op_value;
          end
          res_status <= tpm_pkg::STATUS_OK;
          state      <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            match_value  <= res_match;
            used_default <= res_default;
            status       <= res_status;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
